// ----- design/cfr_pkg.sv -----
// Shared types, constants and the CRC helper for the CRC-checked frame receiver.
package cfr_pkg;

   // Field widths.
   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 16;
   localparam int MAX_LEN_W   = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int STATUS_W    = 2;

   // Configuration defaults and protocol constants.
   localparam int                 LENGTH_WIDTH_DEFAULT = 10;
   localparam int                 FIFO_DEPTH_DEFAULT   = 4;
   localparam logic [BYTE_W-1:0]  SYNC_RESET           = 8'hA5;
   localparam logic [BYTE_W-1:0]  TAIL_RESET           = 8'h5A;
   localparam int                 MAX_LENGTH_RESET     = 515;
   localparam logic [WORD_W-1:0]  MIN_LENGTH           = 16'd3;
   localparam logic [WORD_W-1:0]  CRC_POLY             = 16'hA001;
   localparam logic [WORD_W-1:0]  CRC_INIT             = 16'hFFFF;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SYNC    = 2'd0,
      CSR_TAIL    = 2'd1,
      CSR_MAX_LEN = 2'd2
   } csr_index_type;

   // Receive phases, one per byte position of a frame.
   typedef enum logic [3:0] {
      PH_HUNT, PH_SRC, PH_DST, PH_FN_LO, PH_FN_HI, PH_LEN_LO, PH_LEN_HI,
      PH_CMD_LO, PH_CMD_HI, PH_PAYLOAD, PH_ACK, PH_CRC_LO, PH_CRC_HI, PH_TAIL
   } phase_type;

   // Kind of a result transaction.
   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_END     = 1'b1
   } kind_type;

   // Frame status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_CRC        = 2'd1,
      STATUS_BAD_TAIL   = 2'd2,
      STATUS_BAD_LENGTH = 2'd3
   } status_type;

   // Record handed from the parser to the output stage.
   typedef struct packed {
      kind_type              kind;
      logic [BYTE_W-1:0]     data;
      logic [BYTE_W-1:0]     src;
      logic [BYTE_W-1:0]     dst;
      logic [WORD_W-1:0]     fn;
      logic [WORD_W-1:0]     cmd;
      logic [MAX_LEN_W-1:0]  plen;
      logic                  ack;
      logic                  bad_len;
      logic                  bad_tail;
      logic                  bad_crc;
   } cfr_rec_type;

   // One byte of CRC16 Modbus, reflected, eight bit steps.
   function automatic logic [WORD_W-1:0] crc16_update(input logic [WORD_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] data);
      logic [WORD_W-1:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- design/cfr_front.sv -----
// Frame parser: configuration registers, phase tracking, CRC and header capture.
module cfr_front #(
   parameter int LENGTH_WIDTH = cfr_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [cfr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [cfr_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic                              byte_valid,
   input  logic [cfr_pkg::BYTE_W-1:0]        rx_byte,
   output logic                              rec_push,
   output cfr_pkg::cfr_rec_type              rec
);
   import cfr_pkg::*;

   localparam logic [LENGTH_WIDTH-1:0] MAX_LEN_RST = LENGTH_WIDTH'(MAX_LENGTH_RESET);

   logic [BYTE_W-1:0]       sync_ff, sync_in, tail_ff, tail_in;
   logic [LENGTH_WIDTH-1:0] max_len_ff, max_len_in;
   phase_type               phase_ff, phase_in;
   logic [LENGTH_WIDTH-1:0] count_ff, count_in, plen_ff, plen_in;
   logic [BYTE_W-1:0]       len_lo_ff, len_lo_in;
   logic [WORD_W-1:0]       crc_ff, crc_in, rx_crc_ff, rx_crc_in;
   logic [BYTE_W-1:0]       src_ff, src_in, dst_ff, dst_in;
   logic [WORD_W-1:0]       fn_ff, fn_in, cmd_ff, cmd_in;
   logic                    ack_ff, ack_in;
   logic [WORD_W-1:0]       len_full, len_minus;
   logic [LENGTH_WIDTH-1:0] count_next;
   logic                    len_bad;

   assign len_full   = {rx_byte, len_lo_ff};
   assign len_minus  = len_full - MIN_LENGTH;
   assign len_bad    = (len_full < MIN_LENGTH) || (len_full > WORD_W'(max_len_ff));
   assign count_next = count_ff + 1'b1;

   // Configuration register writes; an unknown index is dropped.
   always_comb begin
      sync_in    = sync_ff;
      tail_in    = tail_ff;
      max_len_in = max_len_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SYNC:    sync_in    = csr_data[BYTE_W-1:0];
            CSR_TAIL:    tail_in    = csr_data[BYTE_W-1:0];
            CSR_MAX_LEN: max_len_in = csr_data[LENGTH_WIDTH-1:0];
            default:     ;
         endcase
      end
   end

   // Per-byte phase step, CRC update and result classification.
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      plen_in   = plen_ff;
      len_lo_in = len_lo_ff;
      crc_in    = crc_ff;
      rx_crc_in = rx_crc_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      fn_in     = fn_ff;
      cmd_in    = cmd_ff;
      ack_in    = ack_ff;
      rec_push  = 1'b0;
      rec.kind     = KIND_PAYLOAD;
      rec.data     = rx_byte;
      rec.src      = src_ff;
      rec.dst      = dst_ff;
      rec.fn       = fn_ff;
      rec.cmd      = cmd_ff;
      rec.plen     = MAX_LEN_W'(plen_ff);
      rec.ack      = ack_ff;
      rec.bad_len  = 1'b0;
      rec.bad_tail = 1'b0;
      rec.bad_crc  = 1'b0;
      if (byte_valid) begin
         if (phase_ff >= PH_SRC && phase_ff <= PH_ACK) begin
            crc_in = crc16_update(crc_ff, rx_byte);
         end
         unique case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == sync_ff) begin
                  crc_in   = CRC_INIT;
                  cmd_in   = '0;
                  count_in = '0;
                  phase_in = PH_SRC;
               end
            end
            PH_SRC:    begin src_in = rx_byte;            phase_in = PH_DST;    end
            PH_DST:    begin dst_in = rx_byte;            phase_in = PH_FN_LO;  end
            PH_FN_LO:  begin fn_in = {8'h00, rx_byte};    phase_in = PH_FN_HI;  end
            PH_FN_HI:  begin fn_in = {rx_byte, fn_ff[7:0]}; phase_in = PH_LEN_LO; end
            PH_LEN_LO: begin len_lo_in = rx_byte;         phase_in = PH_LEN_HI; end
            PH_LEN_HI: begin
               plen_in = len_minus[LENGTH_WIDTH-1:0];
               if (len_bad) begin
                  rec_push    = 1'b1;
                  rec.kind    = KIND_END;
                  rec.bad_len = 1'b1;
                  phase_in    = PH_HUNT;
               end else begin
                  phase_in = PH_CMD_LO;
               end
            end
            PH_CMD_LO: begin cmd_in = {8'h00, rx_byte}; phase_in = PH_CMD_HI; end
            PH_CMD_HI: begin
               cmd_in   = {rx_byte, cmd_ff[7:0]};
               count_in = '0;
               phase_in = (plen_ff == '0) ? PH_ACK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               count_in = count_next;
               if (count_next >= plen_ff) begin
                  phase_in = PH_ACK;
               end
               rec_push = 1'b1;
               rec.ack  = 1'b0;
            end
            PH_ACK:    begin ack_in = (rx_byte != '0);         phase_in = PH_CRC_LO; end
            PH_CRC_LO: begin rx_crc_in = {8'h00, rx_byte};     phase_in = PH_CRC_HI; end
            PH_CRC_HI: begin
               rx_crc_in = {rx_byte, rx_crc_ff[7:0]};
               phase_in  = PH_TAIL;
            end
            PH_TAIL: begin
               rec_push     = 1'b1;
               rec.kind     = KIND_END;
               rec.bad_tail = (rx_byte != tail_ff);
               rec.bad_crc  = (rx_crc_ff != crc_ff);
               phase_in     = PH_HUNT;
            end
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff    <= SYNC_RESET;
         tail_ff    <= TAIL_RESET;
         max_len_ff <= MAX_LEN_RST;
         phase_ff   <= PH_HUNT;
         count_ff   <= '0;
         crc_ff     <= CRC_INIT;
      end else begin
         sync_ff    <= sync_in;
         tail_ff    <= tail_in;
         max_len_ff <= max_len_in;
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         crc_ff     <= crc_in;
      end
   end

   // Frame header and trailer capture.
   always_ff @(posedge clock) begin
      plen_ff   <= plen_in;
      len_lo_ff <= len_lo_in;
      rx_crc_ff <= rx_crc_in;
      src_ff    <= src_in;
      dst_ff    <= dst_in;
      fn_ff     <= fn_in;
      cmd_ff    <= cmd_in;
      ack_ff    <= ack_in;
   end

   // Only the length, payload and tail positions produce records.
   assert property (@(posedge clock) disable iff (reset)
      rec_push |-> (phase_ff == PH_LEN_HI || phase_ff == PH_PAYLOAD || phase_ff == PH_TAIL))
      else $error("record produced outside a reporting phase");

   // A tail byte always returns the parser to hunting.
   assert property (@(posedge clock) disable iff (reset)
      (byte_valid && phase_ff == PH_TAIL) |=> (phase_ff == PH_HUNT))
      else $error("parser did not resume hunting after the tail");

endmodule

// ----- design/cfr_fifo.sv -----
// Small record queue between the frame parser and the output stage.
module cfr_fifo #(
   parameter int DEPTH = cfr_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cfr_pkg::cfr_rec_type  push_data,
   output logic                  full,
   input  logic                  pop,
   output cfr_pkg::cfr_rec_type  pop_data,
   output logic                  empty
);
   import cfr_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   cfr_rec_type      mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == DEPTH_C);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer wrap and occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage write.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // The parser is held off while the queue is full, so no record is dropped.
   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("record pushed into a full queue");

   // Occupancy never exceeds the depth.
   assert property (@(posedge clock) disable iff (reset) count_ff <= DEPTH_C)
      else $error("queue occupancy out of range");

endmodule

// ----- design/cfr_back.sv -----
// Output stage: holds one record and formats the result fields from it.
module cfr_back #(
   parameter int LENGTH_WIDTH = cfr_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fifo_empty,
   input  cfr_pkg::cfr_rec_type            fifo_data,
   output logic                            fifo_pop,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic                            rsp_kind,
   output logic [cfr_pkg::BYTE_W-1:0]      rsp_payload_byte,
   output logic [cfr_pkg::BYTE_W-1:0]      rsp_source_addr,
   output logic [cfr_pkg::BYTE_W-1:0]      rsp_dest_addr,
   output logic [cfr_pkg::WORD_W-1:0]      rsp_frame_number,
   output logic [cfr_pkg::WORD_W-1:0]      rsp_command_code,
   output logic [LENGTH_WIDTH-1:0]         rsp_payload_length,
   output logic                            rsp_ack_requested,
   output logic [cfr_pkg::STATUS_W-1:0]    rsp_frame_status
);
   import cfr_pkg::*;

   cfr_rec_type out_ff, out_in;
   logic        valid_ff, valid_in;
   logic        taken;
   status_type  status;

   // Load a new record when the stage is empty or its transaction completes.
   assign taken    = rsp_pop && valid_ff;
   assign fifo_pop = !fifo_empty && (!valid_ff || taken);

   always_comb begin
      valid_in = valid_ff;
      out_in   = out_ff;
      if (fifo_pop) begin
         valid_in = 1'b1;
         out_in   = fifo_data;
      end else if (taken) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   // Status priority: bad length, bad tail, CRC mismatch; payloads report OK.
   always_comb begin
      priority if (out_ff.kind == KIND_PAYLOAD) status = STATUS_OK;
      else if (out_ff.bad_len)  status = STATUS_BAD_LENGTH;
      else if (out_ff.bad_tail) status = STATUS_BAD_TAIL;
      else if (out_ff.bad_crc)  status = STATUS_CRC;
      else                      status = STATUS_OK;
   end

   // Field masking per result kind and for bad-length reports.
   assign rsp_empty          = !valid_ff;
   assign rsp_kind           = out_ff.kind;
   assign rsp_payload_byte   = (out_ff.kind == KIND_PAYLOAD) ? out_ff.data : '0;
   assign rsp_source_addr    = out_ff.src;
   assign rsp_dest_addr      = out_ff.dst;
   assign rsp_frame_number   = out_ff.fn;
   assign rsp_command_code   = out_ff.bad_len ? '0 : out_ff.cmd;
   assign rsp_payload_length = out_ff.bad_len ? '0 : out_ff.plen[LENGTH_WIDTH-1:0];
   assign rsp_ack_requested  = (out_ff.kind == KIND_END) && !out_ff.bad_len && out_ff.ack;
   assign rsp_frame_status   = status;

   // A waiting record reaches the output register in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (!fifo_empty && !valid_ff) |=> valid_ff)
      else $error("output stage failed to load a waiting record");

endmodule

// ----- design/crc_checked_frame_receiver.sv -----
// Top level of the CRC-checked frame receiver: parser, record queue and output stage.
//
//   Channel   Ports                         Transaction
//   req       req_push / req_full           one received byte
//   rsp       rsp_pop / rsp_empty           one payload byte or end-of-frame report
//   csr       csr_valid / csr_ready         write of register csr_index (0 sync,
//                                           1 tail, 2 max length)
//
// One byte is taken per cycle while req_full is low; a result reaches the rsp ports
// via the queue (written at the edge that takes its byte) and the output register.
// req_full rises only when the record queue is full, i.e. while rsp_pop stays low.
// Reset restores the register defaults and starts hunting for the sync byte.
// csr_ready is always high, so a write is taken whenever csr_valid is high.
module crc_checked_frame_receiver #(
   parameter int LENGTH_WIDTH = cfr_pkg::LENGTH_WIDTH_DEFAULT,
   parameter int FIFO_DEPTH   = cfr_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [cfr_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic                            rsp_kind,
   output logic [cfr_pkg::BYTE_W-1:0]      rsp_payload_byte,
   output logic [cfr_pkg::BYTE_W-1:0]      rsp_source_addr,
   output logic [cfr_pkg::BYTE_W-1:0]      rsp_dest_addr,
   output logic [cfr_pkg::WORD_W-1:0]      rsp_frame_number,
   output logic [cfr_pkg::WORD_W-1:0]      rsp_command_code,
   output logic [LENGTH_WIDTH-1:0]         rsp_payload_length,
   output logic                            rsp_ack_requested,
   output logic [cfr_pkg::STATUS_W-1:0]    rsp_frame_status,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cfr_pkg::CSR_DATA_W-1:0]  csr_data
);
   import cfr_pkg::*;

   cfr_rec_type front_rec, fifo_data;
   logic        front_push, fifo_full, fifo_empty, fifo_pop, accept;

   // Bytes are taken whenever the record queue has room.
   assign req_full  = fifo_full;
   assign accept    = req_push && !fifo_full;
   assign csr_ready = 1'b1;

   cfr_front #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .byte_valid (accept),
      .rx_byte    (req_rx_byte),
      .rec_push   (front_push),
      .rec        (front_rec)
   );

   cfr_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_rec),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .pop_data  (fifo_data),
      .empty     (fifo_empty)
   );

   cfr_back #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_back (
      .clock              (clock),
      .reset              (reset),
      .fifo_empty         (fifo_empty),
      .fifo_data          (fifo_data),
      .fifo_pop           (fifo_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_kind           (rsp_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_source_addr    (rsp_source_addr),
      .rsp_dest_addr      (rsp_dest_addr),
      .rsp_frame_number   (rsp_frame_number),
      .rsp_command_code   (rsp_command_code),
      .rsp_payload_length (rsp_payload_length),
      .rsp_ack_requested  (rsp_ack_requested),
      .rsp_frame_status   (rsp_frame_status)
   );

endmodule
